// ===== hdl/checked_stack_calculator_core_assert.svh =====
// assertion macros for the checked stack calculator
// used by checked_stack_calculator_core, no other dependencies
`ifndef CHECKED_STACK_CALCULATOR_CORE_ASSERT_SVH
`define CHECKED_STACK_CALCULATOR_CORE_ASSERT_SVH

// a property that must hold at every clock edge out of reset
`define CSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a property checked at every clock edge, also during reset
`define CSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/csc_pkg.sv =====
// package for the checked stack calculator: command, status and state codes
// no dependencies
`default_nettype none

package csc_pkg;

    localparam int StackDepthDef = 64;
    localparam int VarSlotsDef   = 64;
    localparam int DataW         = 64;
    localparam int KindW         = 4;
    localparam int SlotW         = 6;
    localparam int StatusW       = 3;

    typedef enum logic [KindW-1:0] {
        K_PUSH_LIT = 4'd0,
        K_PUSH_VAR = 4'd1,
        K_POP      = 4'd2,
        K_PEEK     = 4'd3,
        K_ABS      = 4'd4,
        K_PLUS     = 4'd5,
        K_MINUS    = 4'd6,
        K_MUL      = 4'd7,
        K_DIV      = 4'd8,
        K_PRINT    = 4'd9,
        K_NOP      = 4'd10
    } kind_t;

    typedef enum logic [StatusW-1:0] {
        ST_OK     = 3'd0,
        ST_UNDER  = 3'd1,
        ST_UNKVAR = 3'd2,
        ST_OVF    = 3'd3,
        ST_DIV0   = 3'd4,
        ST_FULL   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_ITER,
        S_FIN,
        S_WB,
        S_TOPRD,
        S_TOPWAIT,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/checked_stack_calculator_core.sv =====
// checked stack calculator top level: sequencer, stack and variable memories,
// shared shift-add multiply / shift-subtract divide unit; uses csc_pkg
`default_nettype none

// One command is taken per request, and the block is busy until its result has
// been taken. A plain command, once accepted, goes through two registered reads
// of the stack memory, a decision, a write-back, a registered read of the new top
// and a step to latch it before its result is presented. A mul or div without an
// error also goes through one shared 64-step shift unit, one bit per cycle, plus
// a finishing step, between the decision and the write-back. The result is held
// until m_tready takes it, and the block then returns to idle before the next
// request. The result carries a status and the stack top after the command; on
// any error the stack and variables are unchanged. Variable slots have valid
// bits that reset clears; stack and variable values themselves are not cleared.
`include "checked_stack_calculator_core_assert.svh"

module checked_stack_calculator_core
    import csc_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepthDef,
    parameter int VAR_SLOTS   = VarSlotsDef
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] kind, [67:4] literal, [73:68] slot, [79:74] zero
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] status, [66:3] top_value, [67] top_valid, [71:68] zero
    output logic [71:0]      m_tdata
);

    localparam int SpW = $clog2(STACK_DEPTH + 1);
    localparam int AdW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int VaW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
    localparam int CntW = $clog2(DataW + 1);
    localparam logic [DataW-1:0] Min64 = {1'b1, {(DataW-1){1'b0}}};

    // memories
    logic [DataW-1:0] stack_mem [STACK_DEPTH];
    logic [DataW-1:0] var_mem [VAR_SLOTS];
    logic [VAR_SLOTS-1:0] var_valid_reg;

    state_t state_reg, state_next;
    logic [KindW-1:0] kind_reg;
    logic [DataW-1:0] lit_reg;
    logic [SlotW-1:0] slot_reg;
    logic [SpW-1:0]   n_reg, n_next;
    logic [DataW-1:0] b_reg, rd_data_reg, var_rd_reg;
    logic [StatusW-1:0] st_reg, st_next;
    logic [DataW-1:0] res_reg, res_next;
    logic             wr_en;
    logic [AdW-1:0]   wr_addr;
    logic [DataW-1:0] wr_data;
    logic             vwr_en;
    logic [AdW-1:0]   rd_addr;
    // shared shift unit
    logic [DataW-1:0] acc_reg, acc_next;   // product or remainder
    logic [DataW-1:0] q_reg, q_next;       // multiplier / quotient bits
    logic [DataW-1:0] ma_reg, mb_reg;
    logic             neg_reg, ovf_reg, ovf_next;
    logic [CntW-1:0]  cnt_reg;
    logic [DataW-1:0] top_reg;
    logic             topv_reg;
    logic             slot_ok;
    logic             sel_div;

    assign slot_ok = (int'(slot_reg) < VAR_SLOTS);
    assign sel_div = (kind_reg == K_DIV);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_RD1;
            S_RD1:     state_next = S_RD2;
            S_RD2:     state_next = S_EXEC;
            S_EXEC:    state_next = ((kind_reg == K_MUL || kind_reg == K_DIV)
                                     && st_next == ST_OK) ? S_ITER : S_WB;
            S_ITER:    if (cnt_reg == CntW'(DataW - 1)) state_next = S_FIN;
            S_FIN:     state_next = S_WB;
            S_WB:      state_next = S_TOPRD;
            S_TOPRD:   state_next = S_TOPWAIT;
            S_TOPWAIT: state_next = S_OUT;
            S_OUT:     if (m_tready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_OUT);
        m_tdata  = {4'b0, topv_reg, top_reg, st_reg};
    end

    // stack read address per state
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rd_addr = '0;
            S_RD1:   rd_addr = AdW'(n_reg - SpW'(1));
            S_RD2:   rd_addr = AdW'(n_reg - SpW'(2));
            default: rd_addr = AdW'(n_reg - SpW'(1));
        endcase
    end

    // command decision; the left operand is the read issued in S_RD2
    always_comb
    begin
        logic [DataW-1:0] s;
        logic [DataW-1:0] d;
        st_next = ST_OK;
        res_next = res_reg;
        n_next = n_reg;
        s = rd_data_reg + b_reg;
        d = rd_data_reg - b_reg;
        unique case (kind_reg)
            K_PUSH_LIT:
                if (n_reg >= SpW'(STACK_DEPTH)) st_next = ST_FULL;
                else res_next = lit_reg;
            K_PUSH_VAR:
                if (!slot_ok || !var_valid_reg[VaW'(slot_reg)]) st_next = ST_UNKVAR;
                else if (n_reg >= SpW'(STACK_DEPTH)) st_next = ST_FULL;
                else res_next = var_rd_reg;
            K_POP, K_PRINT:
                if (n_reg == '0) st_next = ST_UNDER;
            K_PEEK:
                if (n_reg == '0) st_next = ST_UNDER;
                else if (!slot_ok) st_next = ST_UNKVAR;
            K_ABS:
                if (n_reg == '0) st_next = ST_UNDER;
                else if (b_reg == Min64) st_next = ST_OVF;
                else res_next = b_reg[DataW-1] ? -b_reg : b_reg;
            K_PLUS:
                if (n_reg < SpW'(2)) st_next = ST_UNDER;
                else if (((rd_data_reg ^ s) & (b_reg ^ s)) >> (DataW-1) != '0)
                    st_next = ST_OVF;
                else res_next = s;
            K_MINUS:
                if (n_reg < SpW'(2)) st_next = ST_UNDER;
                else if (((rd_data_reg ^ b_reg) & (rd_data_reg ^ d)) >> (DataW-1) != '0)
                    st_next = ST_OVF;
                else res_next = d;
            K_MUL:
                if (n_reg < SpW'(2)) st_next = ST_UNDER;
            K_DIV:
                if (n_reg < SpW'(2)) st_next = ST_UNDER;
                else if (b_reg == '0) st_next = ST_DIV0;
                else if (rd_data_reg == Min64 && b_reg == '1) st_next = ST_OVF;
            default: ;
        endcase
    end

    // one step of the shared shift unit
    always_comb
    begin
        logic [DataW:0] t;
        logic [DataW:0] r;
        acc_next = acc_reg;
        q_next = q_reg;
        ovf_next = ovf_reg;
        t = '0;
        r = '0;
        if (sel_div)
        begin
            // restoring division, one quotient bit per step
            r = {acc_reg, q_reg[DataW-1]};
            t = r - {1'b0, mb_reg};
            if (!t[DataW]) acc_next = t[DataW-1:0];
            else acc_next = r[DataW-1:0];
            q_next = {q_reg[DataW-2:0], ~t[DataW]};
        end
        else
        begin
            // msb-first shift-add multiply with overflow watch
            t = {acc_reg, 1'b0};
            if (acc_reg[DataW-1]) ovf_next = 1'b1;
            if (q_reg[DataW-1]) t = t + {1'b0, ma_reg};
            if (t[DataW]) ovf_next = 1'b1;
            acc_next = t[DataW-1:0];
            q_next = {q_reg[DataW-2:0], 1'b0};
        end
    end

    // write-back controls
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = AdW'(n_reg - SpW'(1));
        wr_data = res_reg;
        vwr_en = 1'b0;
        if (state_reg == S_WB && st_reg == ST_OK)
        begin
            case (kind_reg)
                K_PUSH_LIT, K_PUSH_VAR:
                begin
                    wr_en = 1'b1;
                    wr_addr = AdW'(n_reg);
                end
                K_ABS: wr_en = 1'b1;
                K_PLUS, K_MINUS, K_MUL, K_DIV:
                begin
                    wr_en = 1'b1;
                    wr_addr = AdW'(n_reg - SpW'(2));
                end
                K_PEEK: vwr_en = 1'b1;
                default: ;
            endcase
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (wr_en) stack_mem[wr_addr] <= wr_data;
        rd_data_reg <= stack_mem[rd_addr];
        if (vwr_en) var_mem[VaW'(slot_reg)] <= b_reg;
        var_rd_reg <= var_mem[VaW'(slot_reg)];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            kind_reg <= s_tdata[3:0];
            lit_reg  <= s_tdata[67:4];
            slot_reg <= s_tdata[73:68];
        end
        if (state_reg == S_RD2) b_reg <= rd_data_reg;
        if (state_reg == S_EXEC)
        begin
            st_reg <= st_next;
            res_reg <= res_next;
        end
        else if (state_reg == S_FIN)
        begin
            if (sel_div)
                res_reg <= neg_reg ? -q_reg : q_reg;
            else if (ovf_reg || (acc_reg > (neg_reg ? Min64 : ~Min64)))
                st_reg <= ST_OVF;
            else
                res_reg <= neg_reg ? -acc_reg : acc_reg;
        end
        if (state_reg == S_EXEC)
        begin
            ma_reg <= rd_data_reg[DataW-1] ? -rd_data_reg : rd_data_reg;
            mb_reg <= b_reg[DataW-1] ? -b_reg : b_reg;
            neg_reg <= rd_data_reg[DataW-1] ^ b_reg[DataW-1];
            acc_reg <= '0;
            // dividend for div, multiplier for mul
            if (sel_div) q_reg <= rd_data_reg[DataW-1] ? -rd_data_reg : rd_data_reg;
            else q_reg <= b_reg[DataW-1] ? -b_reg : b_reg;
            ovf_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (state_reg == S_ITER)
        begin
            acc_reg <= acc_next;
            q_reg <= q_next;
            ovf_reg <= ovf_next;
            cnt_reg <= cnt_reg + CntW'(1);
        end
        if (state_reg == S_TOPWAIT)
        begin
            top_reg <= (n_reg != '0) ? rd_data_reg : '0;
            topv_reg <= (n_reg != '0);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg <= '0;
            var_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_WB && st_reg == ST_OK)
            begin
                case (kind_reg)
                    K_PUSH_LIT, K_PUSH_VAR: n_reg <= n_reg + SpW'(1);
                    K_POP, K_PLUS, K_MINUS, K_MUL, K_DIV: n_reg <= n_reg - SpW'(1);
                    K_PEEK: var_valid_reg[VaW'(slot_reg)] <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    `CSC_ASSERT(a_count_max, n_reg <= SpW'(STACK_DEPTH), "stack count beyond depth")
    `CSC_ASSERT(a_busy, (state_reg != S_IDLE) |-> !s_tready, "ready while busy")
    `CSC_ASSERT(a_top_empty, m_tvalid |-> (topv_reg == (n_reg != '0)), "top valid mismatch")
    `CSC_ASSERT(a_excl, !(s_tready && m_tvalid), "ready and result at once")

endmodule

`default_nettype wire
